/* rtl/c3cf_pkg.sv */
// Package for the 3x3 clamp filter: field widths, configuration register
// indexes and the payload structs of the pixel and result channels.
// No dependencies.
package c3cf_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 11;
    localparam int KER_W       = 24;
    localparam int DIM_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int MAX_WIDTH_D = 2048;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KER_LEFT   = 3'd0,
        CFG_KER_MIDDLE = 3'd1,
        CFG_KER_RIGHT  = 3'd2,
        CFG_IMG_WIDTH  = 3'd3,
        CFG_IMG_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             start_of_frame;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] filtered_value;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic             last_of_frame;
    } t_pix_out;

endpackage

/* rtl/c3cf_stream_if.sv */
// Valid/ready stream channel carrying one payload word per handshake.
// The payload type is a parameter; no package dependency.
interface c3cf_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/conv3x3_clamp_filter.sv */
// 3x3 convolution with clamp over a raster pixel stream: two line buffers,
// a 3x3 window, nine products and a clamped sum.
// Depends on c3cf_pkg and c3cf_stream_if.
//
//  channel  | direction | word                                      | handshake
//  ---------+-----------+-------------------------------------------+-------------
//  i_pix    | in        | pixel, start_of_frame                     | valid/ready
//  o_res    | out       | filtered_value, center_row, center_col,   | valid/ready
//           |           | last_of_frame                             |
//  i_cfg_*  | in        | register index, 24-bit data               | write enable
//
// Throughput is one pixel word per cycle while o_res does not stall. A result
// word passes the stages after its pixel is taken: the line-buffer read port
// sets the first stage, the product register the second, the clamp the third.
// Border pixels update state and leave no word. Reset is synchronous; it
// clears counters and valid flags and loads the default configuration. The
// line buffers need no clearing pass, so the block takes pixels in the first
// cycle after reset. A stall on o_res holds only a full output register and
// the unbroken run of full stages behind it; empty stages keep filling.
module conv3x3_clamp_filter
    import c3cf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_D
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    c3cf_stream_if.sink           i_pix,
    c3cf_stream_if.source         o_res
);

    localparam int AW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int CW    = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;
    localparam int PRD_W = 2 * PIX_W + 1;
    localparam int SUM_W = PRD_W + 4;

    // Configuration
    logic [KER_W-1:0] r_ker [3];
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ker[0] <= '0;
            r_ker[1] <= KER_W'(256);
            r_ker[2] <= '0;
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(480);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KER_LEFT:   r_ker[0] <= i_cfg_data[KER_W-1:0];
                CFG_KER_MIDDLE: r_ker[1] <= i_cfg_data[KER_W-1:0];
                CFG_KER_RIGHT:  r_ker[2] <= i_cfg_data[KER_W-1:0];
                CFG_IMG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each stage fills when empty or when it drains
    logic r_s1_v, r_s2_v, r_out_v;
    logic r_s1_prod;
    logic s1_leave, s1_ready, s2_ready, out_ready, in_acc, s2_load;

    assign out_ready = !r_out_v || o_res.ready;
    assign s2_ready  = !r_s2_v || out_ready;
    assign s1_leave  = r_s1_v && (!r_s1_prod || s2_ready);
    assign s1_ready  = !r_s1_v || s1_leave;
    assign s2_load   = r_s1_v && r_s1_prod && s2_ready;
    assign in_acc    = i_pix.valid && s1_ready;
    assign i_pix.ready = s1_ready;

    // Row and column counting at accept
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    w_eff, wm1, col_cl;
    logic [ROW_W-1:0] h_eff, hm1;
    logic [AW-1:0]    c_cur, n_col;
    logic [ROW_W-1:0] r_cur, n_row;
    logic             sof, c_wrap, prod_cur, last_cur;

    always_comb begin
        sof = i_pix.payload.start_of_frame;
        priority if (CW'(r_width) < CW'(3)) begin
            w_eff = CW'(3);
        end else if (CW'(r_width) > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_width);
        end
        wm1    = w_eff - CW'(1);
        h_eff  = (r_height < ROW_W'(3)) ? ROW_W'(3) : r_height;
        hm1    = h_eff - ROW_W'(1);
        // Clamp a column left past a shrunk width onto the last column
        col_cl = (CW'(r_col) >= w_eff) ? wm1 : CW'(r_col);
        c_cur  = sof ? '0 : col_cl[AW-1:0];
        r_cur  = sof ? '0 : r_row;
        c_wrap = CW'(c_cur) >= wm1;
        n_col  = c_wrap ? '0 : c_cur + AW'(1);
        priority if (!c_wrap) begin
            n_row = r_cur;
        end else if (r_cur >= hm1) begin
            n_row = '0;
        end else begin
            n_row = r_cur + ROW_W'(1);
        end
        prod_cur = (r_cur >= ROW_W'(2)) && (c_cur >= AW'(2));
        last_cur = (r_cur >= hm1) && c_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line buffers: read at accept, write back when the word leaves stage 1
    logic [PIX_W-1:0] r_lb_up [MAX_WIDTH];
    logic [PIX_W-1:0] r_lb_lo [MAX_WIDTH];
    logic [PIX_W-1:0] r_q_up, r_q_lo;
    logic [AW-1:0]    r_s1_c;
    logic [ROW_W-1:0] r_s1_r;
    logic [PIX_W-1:0] r_s1_px;
    logic             r_s1_last;
    logic [PIX_W-1:0] top1, mid1;
    logic             r_fwd_v;
    logic [PIX_W-1:0] r_fwd_top, r_fwd_mid;

    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            r_lb_up[r_s1_c] <= mid1;
            r_lb_lo[r_s1_c] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q_up <= r_lb_up[c_cur];
            r_q_lo <= r_lb_lo[c_cur];
        end
    end

    // Bypass the write that lands on the address read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (in_acc) begin
            r_fwd_v <= s1_leave && (r_s1_c == c_cur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_top <= mid1;
            r_fwd_mid <= r_s1_px;
        end
    end

    assign top1 = r_fwd_v ? r_fwd_top : r_q_up;
    assign mid1 = r_fwd_v ? r_fwd_mid : r_q_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_ready) begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_c    <= c_cur;
            r_s1_r    <= r_cur;
            r_s1_px   <= i_pix.payload.pixel;
            r_s1_prod <= prod_cur;
            r_s1_last <= last_cur;
        end
    end

    // Window: [0..2] column c-2, [3..5] column c-1, rows top to bottom
    logic [PIX_W-1:0] r_win [6];

    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top1;
            r_win[4] <= mid1;
            r_win[5] <= r_s1_px;
        end
    end

    // Nine products, registered
    logic [PIX_W-1:0]        taps [9];
    logic signed [PRD_W-1:0] prd  [9];
    logic signed [PRD_W-1:0] r_prd [9];
    logic [ROW_W-1:0]        r_s2_row;
    logic [COL_W-1:0]        r_s2_col;
    logic                    r_s2_last;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            taps[i] = r_win[i];
        end
        taps[6] = top1;
        taps[7] = mid1;
        taps[8] = r_s1_px;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                prd[3*j+i] = $signed({1'b0, taps[3*j+i]})
                           * $signed(r_ker[j][8*i +: 8]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_ready) begin
            r_s2_v <= s2_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_prd     <= prd;
            r_s2_row  <= r_s1_r - ROW_W'(1);
            r_s2_col  <= COL_W'(r_s1_c - AW'(1));
            r_s2_last <= r_s1_last;
        end
    end

    // Sum and clamp into the output register
    logic signed [SUM_W-1:0] sum;
    logic [PIX_W-1:0]        clamped;
    t_pix_out                r_out;

    always_comb begin
        sum = '0;
        for (int k = 0; k < 9; k++) begin
            sum = sum + SUM_W'(r_prd[k]);
        end
        priority if (sum < 0) begin
            clamped = '0;
        end else if (sum > SUM_W'(255)) begin
            clamped = PIX_W'(255);
        end else begin
            clamped = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ready) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s2_v) begin
            r_out.filtered_value <= clamped;
            r_out.center_row     <= r_s2_row;
            r_out.center_col     <= r_s2_col;
            r_out.last_of_frame  <= r_s2_last;
        end
    end

    assign o_res.valid   = r_out_v;
    assign o_res.payload = r_out;

    // A taken pixel always occupies stage 1 in the next cycle
    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_v)
        else $error("accepted pixel lost before stage 1");

    // The bypass is armed only by a same-address write during a read
    a_fwd_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd_v) |-> $past(s1_leave && in_acc))
        else $error("line-buffer bypass armed without a colliding write");

    // Stage 2 fills only from a producing word in stage 1
    a_s2_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s2_v) |-> $past(r_s1_v && r_s1_prod))
        else $error("product stage filled from a border pixel");

    // Results belong to interior rows only
    a_row_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.center_row != '0))
        else $error("result on a border row");

endmodule

/* tb/tb_conv3x3_clamp_filter.sv */
// Self-checking testbench for conv3x3_clamp_filter: streams pixel frames, predicts
// every result word and compares it field by field as it leaves the block.
// Depends on c3cf_pkg, c3cf_stream_if and the filter RTL.
module tb_conv3x3_clamp_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import c3cf_pkg::*;

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int IDLE_PCT        = 23;
    // The block holds a word for three stages; the settle time adds margin.
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 16;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int MAX_PRINTED     = 30;
    localparam int RANDOM_WORDS    = 200;
    localparam int RANDOM_RESULTS  = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WIDE_PIXELS     = 40;
    localparam int TALL_ROWS       = 30;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    c3cf_stream_if #(.T(t_pix_in))  pix_if ();
    c3cf_stream_if #(.T(t_pix_out)) res_if ();

    conv3x3_clamp_filter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Filter predictor: its own copy of the registers, line buffers,
    // window and raster counters, starting from the reset values.
    // ------------------------------------------------------------------
    logic [KER_W-1:0] kernel_col [3] = '{24'd0, 24'd256, 24'd0}; // left, middle, right
    logic [DIM_W-1:0] img_width  = 12'd640;
    logic [DIM_W-1:0] img_height = 12'd480;
    logic [PIX_W-1:0] line_upper [MAX_WIDTH_D];
    logic [PIX_W-1:0] line_lower [MAX_WIDTH_D];
    logic [PIX_W-1:0] win_px [6];   // [0..2] column c-2, [3..5] column c-1, top to bottom
    int unsigned      row_cnt = 0;
    int unsigned      col_cnt = 0;

    // Result words still owed by the block, oldest first
    t_pix_out expected_q [$];

    // Run statistics and control shared between processes
    int unsigned words_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned frames_seen   = 0;
    int unsigned cycle_cnt     = 0;
    bit          src_idle_en   = 1'b1;
    bit          snk_stall_en  = 1'b1;
    bit          hold_request  = 1'b0;
    bit          hold_done     = 1'b0;
    int unsigned hold_left     = 0;
    t_pix_out    got_word;
    t_pix_out    want_word;

    // Width saturates at both ends, height only from below
    function automatic int unsigned eff_width();
        if (img_width < 3) return 3;
        if (img_width > MAX_WIDTH_D) return MAX_WIDTH_D;
        return 32'(img_width);
    endfunction

    function automatic int unsigned eff_height();
        return (img_height < 3) ? 3 : 32'(img_height);
    endfunction

    // Byte b of a kernel column register as a signed coefficient
    function automatic int coef_of(input logic [KER_W-1:0] kv, input int b);
        return int'($signed(kv[8*b +: 8]));
    endfunction

    // Advance the predictor by one accepted pixel word; queue the result it owes.
    function automatic void predict_pixel(input logic [PIX_W-1:0] px, input logic sof);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] right_px [3];
        int               acc;
        t_pix_out         res_word;

        w = eff_width();
        h = eff_height();
        if (sof) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        // A width shrunk under a running row pins the column to the new edge
        if (col_cnt >= w) col_cnt = w - 1;
        c = col_cnt;
        r = row_cnt;
        if (r == 0 && c == 0) frames_seen++;

        top = line_upper[c];
        mid = line_lower[c];
        right_px = '{top, mid, px};

        if (r >= 2 && c >= 2) begin
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                acc += int'(win_px[i])     * coef_of(kernel_col[0], i)
                     + int'(win_px[3 + i]) * coef_of(kernel_col[1], i)
                     + int'(right_px[i])   * coef_of(kernel_col[2], i);
            end
            if (acc < 0) acc = 0;
            else if (acc > 255) acc = 255;
            res_word.filtered_value = PIX_W'(acc);
            res_word.center_row     = ROW_W'(r - 1);
            res_word.center_col     = COL_W'(c - 1);
            res_word.last_of_frame  = (r >= h - 1) && (c >= w - 1);
            expected_q.push_back(res_word);
        end

        for (int i = 0; i < 3; i++) begin
            win_px[i]     = win_px[3 + i];
            win_px[3 + i] = right_px[i];
        end
        line_upper[c] = mid;
        line_lower[c] = px;

        // Wrap at the row end; wrap the row at the frame end even without a start mark
        if (c >= w - 1) begin
            col_cnt = 0;
            row_cnt = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting: one line per failure, print only the first few.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTED)
            $display("%0t ns: result word %0d, %s: got %0d, want %0d",
                     $time, words_checked, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result side: drive ready (random stalls, a long hold-off or always ready) and check
    // every accepted word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request && !hold_done) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            // Hold off so the block fills up and stalls its pixel input
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (snk_stall_en) begin
            res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_word = res_if.payload;
            if (expected_q.size() == 0) begin
                report_mismatch("word with nothing expected", got_word.filtered_value, 'x);
            end else begin
                want_word = expected_q.pop_front();
                if (got_word.filtered_value !== want_word.filtered_value)
                    report_mismatch("filtered_value", got_word.filtered_value,
                                    want_word.filtered_value);
                if (got_word.center_row !== want_word.center_row)
                    report_mismatch("center_row", got_word.center_row, want_word.center_row);
                if (got_word.center_col !== want_word.center_col)
                    report_mismatch("center_col", got_word.center_col, want_word.center_col);
                if (got_word.last_of_frame !== want_word.last_of_frame)
                    report_mismatch("last_of_frame", got_word.last_of_frame,
                                    want_word.last_of_frame);
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Pixel side helpers. Every task starts and ends at a rising edge.
    // ------------------------------------------------------------------

    // Offer one pixel word, idling first at random; return once it is taken.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic sof);
        t_pix_in pix_word;

        pix_word.pixel = px;
        pix_word.start_of_frame = sof;
        while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.payload <= pix_word;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        predict_pixel(px, sof);
        words_sent++;
    endtask

    task automatic send_random_pixels(input int unsigned count, input bit sof_first,
                                      input int unsigned pix_max);
        for (int unsigned k = 0; k < count; k++)
            send_pixel(PIX_W'($urandom_range(pix_max)), sof_first && k == 0);
    endtask

    // Drop valid, wait for every owed word, then let trailing border pixels settle.
    task automatic drain_block();
        pix_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; only called with the block drained.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_KER_LEFT:   kernel_col[0] = data;
            CFG_KER_MIDDLE: kernel_col[1] = data;
            CFG_KER_RIGHT:  kernel_col[2] = data;
            CFG_IMG_WIDTH:  img_width  = data[DIM_W-1:0];
            CFG_IMG_HEIGHT: img_height = data[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_kernel(input logic [KER_W-1:0] left, input logic [KER_W-1:0] middle,
                                input logic [KER_W-1:0] right);
        write_reg(CFG_KER_LEFT, left);
        write_reg(CFG_KER_MIDDLE, middle);
        write_reg(CFG_KER_RIGHT, right);
    endtask

    task automatic write_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_reg(CFG_IMG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMG_HEIGHT, CFG_DATA_W'(h));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset kernel is the identity; then both clamp rails with extreme
    // coefficients, a frame that restarts by wrapping alone, and one cut
    // short by an early start mark.
    task automatic test_identity_and_clamp();
        logic [PIX_W-1:0] ring [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd200,
                                       8'd255, 8'd0, 8'd255, 8'd0};

        write_size(12'd3, 12'd3);
        foreach (ring[k]) send_pixel(ring[k], k == 0);

        drain_block();
        write_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        // No start mark: the counters wrapped at the end of the last frame
        for (int k = 0; k < 9; k++) send_pixel(8'd255, 1'b0);

        drain_block();
        write_kernel(24'h808080, 24'h808080, 24'h808080);
        send_pixel(8'd17, 1'b1);
        send_pixel(8'd99, 1'b0);
        for (int k = 0; k < 9; k++) send_pixel(PIX_W'($urandom_range(255, 1)), k == 0);
    endtask

    // Width and height below the legal range act as 3.
    task automatic test_size_limits();
        drain_block();
        write_kernel(24'h00FF00, 24'hFF05FF, 24'h00FF00);
        write_size(12'd0, 12'd2);
        send_random_pixels(9, 1'b1, 255);
        drain_block();
        write_size(12'd2, 12'd0);
        send_random_pixels(9, 1'b1, 255);
    endtask

    // A width past the buffer depth saturates at the full line length; the
    // first row runs on and leaves no result word.
    task automatic test_wide_frame();
        drain_block();
        write_kernel(24'hFFFEFF, 24'h000100, 24'h010201);
        write_size(12'd4095, 12'd1);
        send_random_pixels(WIDE_PIXELS, 1'b1, 255);
    endtask

    // Narrowest frame at full height, streamed with no idling on either side.
    task automatic test_tall_frame();
        drain_block();
        write_kernel(24'h010101, 24'h010101, 24'h010101);
        write_size(12'd2, 12'd4095);
        src_idle_en  = 1'b0;
        snk_stall_en = 1'b0;
        send_random_pixels(3 * TALL_ROWS, 1'b1, 40);
        src_idle_en  = 1'b1;
        snk_stall_en = 1'b1;
    endtask

    // Registers changed inside a frame: width shrunk under the running row,
    // a new kernel, and a height below the current row.
    task automatic test_midframe_changes();
        drain_block();
        write_kernel(24'hFFFEFF, 24'h000100, 24'h010201);
        write_size(12'd8, 12'd6);
        send_random_pixels(2 * 8 + 7, 1'b1, 255);
        drain_block();
        write_reg(CFG_IMG_WIDTH, 24'd5);
        send_random_pixels(8, 1'b0, 255);
        drain_block();
        write_reg(CFG_KER_MIDDLE, 24'h000300);
        send_random_pixels(3, 1'b0, 80);
        drain_block();
        write_reg(CFG_IMG_HEIGHT, 24'd4);
        send_random_pixels(20, 1'b0, 255);
    endtask

    // Long receiver hold-off while the sender keeps offering words.
    task automatic test_backpressure();
        drain_block();
        write_kernel(24'($urandom), 24'($urandom), 24'($urandom));
        write_size(12'd10, 12'd10);
        src_idle_en  = 1'b0;
        snk_stall_en = 1'b0;
        hold_request = 1'b1;
        send_random_pixels(100, 1'b1, 255);
        src_idle_en  = 1'b1;
        snk_stall_en = 1'b1;
    endtask

    // Mostly complete frames of random size, kernel and content; some cut
    // short, some started by wrapping alone, with stray start marks as noise.
    // A frame on new sizes always opens with a start mark.
    task automatic test_random_frames();
        int unsigned      sent_at_start;
        int unsigned      checked_at_start;
        int unsigned      pick;
        int unsigned      kmode;
        int unsigned      pmode;
        int unsigned      n;
        logic [DIM_W-1:0] new_w;
        logic [DIM_W-1:0] new_h;
        logic [KER_W-1:0] kv [3];
        logic [PIX_W-1:0] px;
        bit               lead_sof;
        bit               reconf;

        sent_at_start    = words_sent;
        checked_at_start = words_checked;
        while (words_sent - sent_at_start < RANDOM_WORDS
               || words_checked - checked_at_start < RANDOM_RESULTS) begin
            reconf = 1'b0;
            // Reconfigure now and then; otherwise stream frames back to back
            if ($urandom_range(2) == 0) begin
                reconf = 1'b1;
                pick = $urandom_range(99);
                if (pick < 80) begin
                    new_w = DIM_W'($urandom_range(12, 3));
                    new_h = DIM_W'($urandom_range(7, 3));
                end else if (pick < 90) begin
                    new_w = DIM_W'($urandom_range(2));
                    new_h = DIM_W'($urandom_range(2));
                end else begin
                    new_w = DIM_W'($urandom_range(48, 20));
                    new_h = DIM_W'($urandom_range(4, 3));
                end
                // Taps are full range, small (-3 to 3) or 0/1; full-range taps clamp a lot
                kmode = $urandom_range(2);
                for (int col = 0; col < 3; col++) begin
                    for (int b = 0; b < 3; b++) begin
                        case (kmode)
                            0:       kv[col][8*b +: 8] = 8'($urandom_range(255));
                            1:       kv[col][8*b +: 8] = 8'($urandom_range(6) - 3);
                            default: kv[col][8*b +: 8] = 8'($urandom_range(1));
                        endcase
                    end
                end
                drain_block();
                write_kernel(kv[0], kv[1], kv[2]);
                write_size(new_w, new_h);
            end

            n = eff_width() * eff_height();
            if ($urandom_range(9) == 0) n = $urandom_range(n - 1, 1);
            lead_sof = reconf || ($urandom_range(9) != 0);
            pmode = $urandom_range(2);
            for (int unsigned k = 0; k < n; k++) begin
                case (pmode)
                    0:       px = PIX_W'($urandom_range(255));
                    1:       px = PIX_W'($urandom_range(31));
                    default: px = $urandom_range(1) ? 8'hFF : 8'h00;
                endcase
                send_pixel(px, (k == 0 && lead_sof) || $urandom_range(63) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, tests in turn, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_KER_LEFT;
        i_cfg_data     <= '0;
        pix_if.valid   <= 1'b0;
        pix_if.payload <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_and_clamp();
        test_size_limits();
        test_wide_frame();
        test_tall_frame();
        test_midframe_changes();
        test_backpressure();
        test_random_frames();

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d pixel words in %0d frames, %0d result words checked.",
                 words_sent, frames_seen, words_checked);
        $display("Full frames up to 48 wide, sizes below and above the legal range,");
        $display("register changes in and between frames, random stalls on both sides");
        $display("and a %0d-cycle output hold-off.", HOLD_OFF_CYCLES);
        if (mismatch_cnt == 0) begin
            $display("tb_conv3x3_clamp_filter: clean");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("tb_conv3x3_clamp_filter: errors");
        end
        $finish;
    end

    // Watchdog: end the run if it hangs
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d result words still owed",
                 cycle_cnt, expected_q.size());
        $display("tb_conv3x3_clamp_filter: errors");
        $finish;
    end

endmodule
